// ===== rtl/trcs_pkg.sv =====
// Shared widths, mode codes, stage records and helper functions for the tensor rotation block.
`default_nettype none

package trcs_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int COEF_WIDTH_DEF = 16;
  localparam int DATA_MIN_W     = 2;
  localparam int COEF_MIN_W     = 12;

  localparam int MODE_W  = 2;
  localparam int FIELD_W = 32;
  localparam int COEF_W  = 16;
  localparam int SQ_W    = 2 * COEF_W;
  localparam int SUM_W   = FIELD_W + 1;
  localparam int PROD_W  = COEF_W + FIELD_W;
  localparam int MUL_W   = COEF_W + SUM_W;
  localparam int NUM_W   = MUL_W + 3;
  localparam int RES_W   = 41;
  localparam int NUM_OUT = 8;

  localparam logic [MODE_W-1:0] MODE_SIX_FWD  = 2'b00;
  localparam logic [MODE_W-1:0] MODE_SIX_INV  = 2'b01;
  localparam logic [MODE_W-1:0] MODE_NINE_FWD = 2'b10;
  localparam logic [MODE_W-1:0] MODE_NINE_INV = 2'b11;
  localparam int MODE_INV_BIT  = 0;
  localparam int MODE_NINE_BIT = 1;

  typedef logic signed [FIELD_W-1:0] field_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [SQ_W-1:0]    sq_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [MUL_W-1:0]   mul_t;
  typedef logic signed [NUM_W-1:0]   num_t;
  typedef logic signed [RES_W-1:0]   res_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    coef_t  sine_theta;
    coef_t  cosine_theta;
    field_t axial_first;
    field_t axial_last;
    field_t cross_upper;
    field_t cross_lower;
    field_t pair_a_first;
    field_t pair_a_second;
    field_t pair_b_first;
    field_t pair_b_second;
    logic   last_item;
  } in_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              last;
  } ctl_t;

  typedef struct packed {
    ctl_t  ctl;
    sq_t   sc;
    sq_t   cc;
    sq_t   ss;
    sum_t  sum08;
    sum_t  dif08;
    sum_t  sum26;
    sum_t  dif26;
    field_t cu;
    prod_t pc3;
    prod_t ps5;
    prod_t pc5;
    prod_t ps3;
    prod_t bc1;
    prod_t bs7;
    prod_t bc7;
    prod_t bs1;
  } s1_t;

  typedef struct packed {
    ctl_t   ctl;
    coef_t  s2;
    coef_t  c2;
    sum_t   sum08;
    sum_t   dif08;
    sum_t   sum26;
    sum_t   dif26;
    field_t cu;
    res_t   r4;
    res_t   r5;
    res_t   r6;
    res_t   r7;
  } s2_t;

  typedef struct packed {
    ctl_t ctl;
    sum_t sum08;
    sum_t dif26;
    mul_t m0c;
    mul_t m0s;
    mul_t m2c;
    mul_t m2s;
    res_t r4;
    res_t r5;
    res_t r6;
    res_t r7;
  } s3_t;

  typedef struct packed {
    ctl_t ctl;
    sum_t sum08;
    sum_t dif26;
    res_t r0;
    res_t r2;
    res_t r4;
    res_t r5;
    res_t r6;
    res_t r7;
  } s4_t;

  typedef struct packed {
    field_t out_axial_first;
    field_t out_axial_last;
    field_t out_cross_upper;
    field_t out_cross_lower;
    field_t out_pair_a_first;
    field_t out_pair_a_second;
    field_t out_pair_b_first;
    field_t out_pair_b_second;
    logic   overflow;
    logic   last_out;
  } out_t;

  function automatic int frac_bits(input int cw);
    int c;
    c = cw;
    if (c > COEF_W) c = COEF_W;
    if (c < COEF_MIN_W) c = COEF_MIN_W;
    return c - 1;
  endfunction

  function automatic int sat_bits(input int dw);
    int d;
    d = dw;
    if (d > FIELD_W) d = FIELD_W;
    if (d < DATA_MIN_W) d = DATA_MIN_W;
    return d;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/trcs_if.sv =====
// Valid/ready stream interfaces for the input tensor beats and the rotated result beats.
`default_nettype none

interface trcs_in_if import trcs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  coef_t             sine_theta;
  coef_t             cosine_theta;
  field_t            axial_first;
  field_t            axial_last;
  field_t            cross_upper;
  field_t            cross_lower;
  field_t            pair_a_first;
  field_t            pair_a_second;
  field_t            pair_b_first;
  field_t            pair_b_second;
  logic              last_item;

  modport source (
    output valid, mode, sine_theta, cosine_theta, axial_first, axial_last, cross_upper,
           cross_lower, pair_a_first, pair_a_second, pair_b_first, pair_b_second, last_item,
    input  ready
  );
  modport sink (
    input  valid, mode, sine_theta, cosine_theta, axial_first, axial_last, cross_upper,
           cross_lower, pair_a_first, pair_a_second, pair_b_first, pair_b_second, last_item,
    output ready
  );
endinterface

interface trcs_out_if import trcs_pkg::*; ();
  logic   valid;
  logic   ready;
  field_t out_axial_first;
  field_t out_axial_last;
  field_t out_cross_upper;
  field_t out_cross_lower;
  field_t out_pair_a_first;
  field_t out_pair_a_second;
  field_t out_pair_b_first;
  field_t out_pair_b_second;
  logic   overflow;
  logic   last_out;

  modport source (
    output valid, out_axial_first, out_axial_last, out_cross_upper, out_cross_lower,
           out_pair_a_first, out_pair_a_second, out_pair_b_first, out_pair_b_second,
           overflow, last_out,
    input  ready
  );
  modport sink (
    input  valid, out_axial_first, out_axial_last, out_cross_upper, out_cross_lower,
           out_pair_a_first, out_pair_a_second, out_pair_b_first, out_pair_b_second,
           overflow, last_out,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/tensor_rotation_cyl_sph.sv =====
// Top level of the cylindrical/spherical tensor rotation pipeline.
// The block takes one tensor beat on in_i and returns one rotated beat on out_o.
// Both channels are valid/ready streams; a beat moves when valid and ready are high.
// A tensor enters in six- or nine-component form with the sine and cosine of theta;
// mode selects the form and the direction of the rotation.
// An accepted beat passes through five register stages (prep, angle, two in rot, sat)
// and is offered on out_o from the output register of the last of them.
// Throughput is one beat per cycle while out_o.ready stays high; each stage holds one beat
// and moves it on whenever the stage after it is empty or moving too.
// When the receiver stalls, the output beat holds and the stages behind it fill;
// in_i.ready falls only when all five stages hold a beat and the output is stalled.
// Reset clears every stage valid bit, so the pipeline comes up empty and ready.
// The last_item marker travels with its beat and appears as last_out.
`default_nettype none

module tensor_rotation_cyl_sph import trcs_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  trcs_in_if.sink     in_i,
  trcs_out_if.source  out_o
);

  logic en1, en2, en3, en4, en5;
  logic v1, v2, v3, v4, v5;
  in_t  in_beat;
  s1_t  s1;
  s2_t  s2;
  s4_t  s4;
  out_t ob;

  always_comb begin
    in_beat.mode          = in_i.mode;
    in_beat.sine_theta    = in_i.sine_theta;
    in_beat.cosine_theta  = in_i.cosine_theta;
    in_beat.axial_first   = in_i.axial_first;
    in_beat.axial_last    = in_i.axial_last;
    in_beat.cross_upper   = in_i.cross_upper;
    in_beat.cross_lower   = in_i.cross_lower;
    in_beat.pair_a_first  = in_i.pair_a_first;
    in_beat.pair_a_second = in_i.pair_a_second;
    in_beat.pair_b_first  = in_i.pair_b_first;
    in_beat.pair_b_second = in_i.pair_b_second;
    in_beat.last_item     = in_i.last_item;
  end

  assign en5 = !v5 || out_o.ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_i.ready = en1;

  trcs_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en1),
    .valid_i (in_i.valid),
    .beat_i  (in_beat),
    .valid_o (v1),
    .stage_o (s1)
  );

  trcs_angle #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en2),
    .valid_i (v1),
    .stage_i (s1),
    .valid_o (v2),
    .stage_o (s2)
  );

  trcs_rot #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_rot (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en3_i    (en3),
    .en4_i    (en4),
    .valid_i  (v2),
    .stage_i  (s2),
    .valid3_o (v3),
    .valid_o  (v4),
    .stage_o  (s4)
  );

  trcs_sat #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_sat (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en5),
    .valid_i (v4),
    .stage_i (s4),
    .valid_o (v5),
    .beat_o  (ob)
  );

  assign out_o.valid             = v5;
  assign out_o.out_axial_first   = ob.out_axial_first;
  assign out_o.out_axial_last    = ob.out_axial_last;
  assign out_o.out_cross_upper   = ob.out_cross_upper;
  assign out_o.out_cross_lower   = ob.out_cross_lower;
  assign out_o.out_pair_a_first  = ob.out_pair_a_first;
  assign out_o.out_pair_a_second = ob.out_pair_a_second;
  assign out_o.out_pair_b_first  = ob.out_pair_b_first;
  assign out_o.out_pair_b_second = ob.out_pair_b_second;
  assign out_o.overflow          = ob.overflow;
  assign out_o.last_out          = ob.last_out;

  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_o.valid |-> in_i.ready)
    else $error("Input stalled although the output stage is empty.");

  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1 && v2 && v4 && v5 && !out_o.ready && !en3) |-> !in_i.ready)
    else $error("Input accepted into a full, stalled pipeline.");

  a_six_form_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4 && en5 && (s4.ctl.mode == MODE_SIX_FWD || s4.ctl.mode == MODE_SIX_INV)) |=>
    (out_o.out_cross_lower == '0 && out_o.out_pair_b_first == '0 &&
     out_o.out_pair_b_second == '0))
    else $error("Six-component beat carries nonzero unused components.");

endmodule

`default_nettype wire

// ===== rtl/trcs_prep.sv =====
// First stage: angle products, axial and cross sums and differences, and the pair products.
`default_nettype none

module trcs_prep import trcs_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire in_t  beat_i,
  output logic      valid_o,
  output s1_t       stage_o
);

  logic v_q;
  s1_t  stage_d, stage_q;

  always_comb begin
    stage_d.ctl.mode = beat_i.mode;
    stage_d.ctl.last = beat_i.last_item;
    stage_d.sc    = beat_i.sine_theta * beat_i.cosine_theta;
    stage_d.cc    = beat_i.cosine_theta * beat_i.cosine_theta;
    stage_d.ss    = beat_i.sine_theta * beat_i.sine_theta;
    stage_d.sum08 = SUM_W'(beat_i.axial_first) + SUM_W'(beat_i.axial_last);
    stage_d.dif08 = SUM_W'(beat_i.axial_first) - SUM_W'(beat_i.axial_last);
    stage_d.sum26 = SUM_W'(beat_i.cross_upper) + SUM_W'(beat_i.cross_lower);
    stage_d.dif26 = SUM_W'(beat_i.cross_upper) - SUM_W'(beat_i.cross_lower);
    stage_d.cu    = beat_i.cross_upper;
    stage_d.pc3   = beat_i.cosine_theta * beat_i.pair_a_first;
    stage_d.ps5   = beat_i.sine_theta * beat_i.pair_a_second;
    stage_d.pc5   = beat_i.cosine_theta * beat_i.pair_a_second;
    stage_d.ps3   = beat_i.sine_theta * beat_i.pair_a_first;
    stage_d.bc1   = beat_i.cosine_theta * beat_i.pair_b_first;
    stage_d.bs7   = beat_i.sine_theta * beat_i.pair_b_second;
    stage_d.bc7   = beat_i.cosine_theta * beat_i.pair_b_second;
    stage_d.bs1   = beat_i.sine_theta * beat_i.pair_b_first;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = v_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ===== rtl/trcs_angle.sv =====
// Second stage: rounded double-angle terms and the rounded in-plane pair rotations.
`default_nettype none

module trcs_angle import trcs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire s1_t  stage_i,
  output logic      valid_o,
  output s2_t       stage_o
);

  localparam int FRAC = frac_bits(COEF_WIDTH);
  localparam int AW   = SQ_W + 2;
  localparam logic signed [AW-1:0]    ONE_A  = AW'(1) <<< FRAC;
  localparam logic signed [AW-1:0]    HALF_A = AW'(1) <<< (FRAC - 1);
  localparam logic signed [MUL_W-1:0] HALF_M = MUL_W'(1) <<< (FRAC - 1);

  logic v_q;
  s2_t  stage_d, stage_q;
  logic signed [AW-1:0]    ts, tc, us, uc;
  logic signed [MUL_W-1:0] a4, a5, a6, a7;
  logic                    gneg, sgneg;

  function automatic coef_t clamp_coef(input logic signed [AW-1:0] x);
    logic signed [AW-1:0] y;
    y = x;
    if (x > ONE_A - AW'(1)) y = ONE_A - AW'(1);
    if (x < -ONE_A) y = -ONE_A;
    return COEF_W'(y);
  endfunction

  always_comb begin
    sgneg = stage_i.ctl.mode[MODE_INV_BIT];
    gneg  = stage_i.ctl.mode[MODE_INV_BIT] == stage_i.ctl.mode[MODE_NINE_BIT];
    ts = (AW'(stage_i.sc) <<< 1) + HALF_A;
    tc = AW'(stage_i.cc) - AW'(stage_i.ss) + HALF_A;
    us = ts >>> FRAC;
    uc = tc >>> FRAC;
    a4 = gneg  ? MUL_W'(stage_i.pc3) + MUL_W'(stage_i.ps5)
               : MUL_W'(stage_i.pc3) - MUL_W'(stage_i.ps5);
    a5 = gneg  ? MUL_W'(stage_i.pc5) - MUL_W'(stage_i.ps3)
               : MUL_W'(stage_i.pc5) + MUL_W'(stage_i.ps3);
    a6 = sgneg ? MUL_W'(stage_i.bc1) + MUL_W'(stage_i.bs7)
               : MUL_W'(stage_i.bc1) - MUL_W'(stage_i.bs7);
    a7 = sgneg ? MUL_W'(stage_i.bc7) - MUL_W'(stage_i.bs1)
               : MUL_W'(stage_i.bc7) + MUL_W'(stage_i.bs1);

    stage_d.ctl   = stage_i.ctl;
    stage_d.s2    = clamp_coef(us);
    stage_d.c2    = clamp_coef(uc);
    stage_d.sum08 = stage_i.sum08;
    stage_d.dif08 = stage_i.dif08;
    stage_d.sum26 = stage_i.sum26;
    stage_d.dif26 = stage_i.dif26;
    stage_d.cu    = stage_i.cu;
    stage_d.r4    = RES_W'((a4 + HALF_M) >>> FRAC);
    stage_d.r5    = RES_W'((a5 + HALF_M) >>> FRAC);
    stage_d.r6    = RES_W'((a6 + HALF_M) >>> FRAC);
    stage_d.r7    = RES_W'((a7 + HALF_M) >>> FRAC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = v_q;
  assign stage_o = stage_q;

endmodule

`default_nettype wire

// ===== rtl/trcs_rot.sv =====
// Third and fourth stages: double-angle products, then the summed and rounded axial terms.
`default_nettype none

module trcs_rot import trcs_pkg::*; #(
  parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en3_i,
  input  wire logic en4_i,
  input  wire logic valid_i,
  input  wire s2_t  stage_i,
  output logic      valid3_o,
  output logic      valid_o,
  output s4_t       stage_o
);

  localparam int FRAC = frac_bits(COEF_WIDTH);
  localparam logic signed [NUM_W-1:0] HALF_N = NUM_W'(1) <<< FRAC;

  logic v3_q, v4_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  sum_t q_op;
  num_t base0, base2, c0, c2x, s0, s2x, n0, n2;

  always_comb begin
    q_op = stage_i.ctl.mode[MODE_NINE_BIT] ? stage_i.sum26 : SUM_W'(stage_i.cu);
    s3_d.ctl   = stage_i.ctl;
    s3_d.sum08 = stage_i.sum08;
    s3_d.dif26 = stage_i.dif26;
    s3_d.m0c   = stage_i.c2 * stage_i.dif08;
    s3_d.m0s   = stage_i.s2 * q_op;
    s3_d.m2c   = stage_i.c2 * q_op;
    s3_d.m2s   = stage_i.s2 * stage_i.dif08;
    s3_d.r4    = stage_i.r4;
    s3_d.r5    = stage_i.r5;
    s3_d.r6    = stage_i.r6;
    s3_d.r7    = stage_i.r7;
  end

  always_comb begin
    base0 = NUM_W'(s3_q.sum08) <<< FRAC;
    base2 = NUM_W'(s3_q.dif26) <<< FRAC;
    c0    = NUM_W'(s3_q.m0c);
    c2x   = NUM_W'(s3_q.m2c);
    s0    = NUM_W'(s3_q.m0s);
    s2x   = NUM_W'(s3_q.m2s);
    unique case (s3_q.ctl.mode)
      MODE_SIX_FWD: begin
        n0 = base0 + c0 - s0;
        n2 = (c2x <<< 1) + (s2x <<< 1);
      end
      MODE_SIX_INV: begin
        n0 = base0 + c0 + (s0 <<< 1);
        n2 = (c2x <<< 1) - s2x;
      end
      MODE_NINE_FWD: begin
        n0 = base0 + c0 - s0;
        n2 = base2 + c2x + s2x;
      end
      MODE_NINE_INV: begin
        n0 = base0 + c0 + s0;
        n2 = base2 + c2x - s2x;
      end
      default: begin
        n0 = '0;
        n2 = '0;
      end
    endcase
    s4_d.ctl   = s3_q.ctl;
    s4_d.sum08 = s3_q.sum08;
    s4_d.dif26 = s3_q.dif26;
    s4_d.r0    = RES_W'((n0 + HALF_N) >>> (FRAC + 1));
    s4_d.r2    = RES_W'((n2 + HALF_N) >>> (FRAC + 1));
    s4_d.r4    = s3_q.r4;
    s4_d.r5    = s3_q.r5;
    s4_d.r6    = s3_q.r6;
    s4_d.r7    = s3_q.r7;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3_i) v3_q <= valid_i;
      if (en4_i) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3_i) s3_q <= s3_d;
    if (en4_i) s4_q <= s4_d;
  end

  assign valid3_o = v3_q;
  assign valid_o  = v4_q;
  assign stage_o  = s4_q;

endmodule

`default_nettype wire

// ===== rtl/trcs_sat.sv =====
// Fifth stage: complementary components, saturation, overflow flag and the output register.
`default_nettype none

module trcs_sat import trcs_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic en_i,
  input  wire logic valid_i,
  input  wire s4_t  stage_i,
  output logic      valid_o,
  output out_t      beat_o
);

  localparam int SW = sat_bits(DATA_WIDTH);
  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((longint'(1) <<< (SW - 1)) - longint'(1));
  localparam logic signed [RES_W-1:0] SAT_LO = ~SAT_HI;

  logic   v_q;
  out_t   beat_d, beat_q;
  logic   nine;
  res_t   res  [NUM_OUT];
  field_t outv [NUM_OUT];
  logic   ovf;

  always_comb begin
    nine   = stage_i.ctl.mode[MODE_NINE_BIT];
    res[0] = stage_i.r0;
    res[1] = RES_W'(stage_i.sum08) - stage_i.r0;
    res[2] = stage_i.r2;
    res[3] = nine ? stage_i.r2 - RES_W'(stage_i.dif26) : '0;
    res[4] = stage_i.r4;
    res[5] = stage_i.r5;
    res[6] = nine ? stage_i.r6 : '0;
    res[7] = nine ? stage_i.r7 : '0;
    ovf = 1'b0;
    for (int k = 0; k < NUM_OUT; k++) begin
      if (res[k] > SAT_HI) begin
        outv[k] = FIELD_W'(SAT_HI);
        ovf     = 1'b1;
      end else if (res[k] < SAT_LO) begin
        outv[k] = FIELD_W'(SAT_LO);
        ovf     = 1'b1;
      end else begin
        outv[k] = FIELD_W'(res[k]);
      end
    end
    beat_d.out_axial_first   = outv[0];
    beat_d.out_axial_last    = outv[1];
    beat_d.out_cross_upper   = outv[2];
    beat_d.out_cross_lower   = outv[3];
    beat_d.out_pair_a_first  = outv[4];
    beat_d.out_pair_a_second = outv[5];
    beat_d.out_pair_b_first  = outv[6];
    beat_d.out_pair_b_second = outv[7];
    beat_d.overflow          = ovf;
    beat_d.last_out          = stage_i.ctl.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (en_i) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      beat_q <= beat_d;
    end
  end

  assign valid_o = v_q;
  assign beat_o  = beat_q;

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the cylindrical/spherical tensor rotation pipeline.
module testbench;
  import trcs_pkg::*;

  localparam int DUT_DATA_WIDTH = 32;
  localparam int DUT_COEF_WIDTH = 16;
  localparam int DW = DUT_DATA_WIDTH > FIELD_W ? FIELD_W :
                      (DUT_DATA_WIDTH < DATA_MIN_W ? DATA_MIN_W : DUT_DATA_WIDTH);
  localparam int FRAC = (DUT_COEF_WIDTH > COEF_W ? COEF_W :
                        (DUT_COEF_WIDTH < COEF_MIN_W ? COEF_MIN_W : DUT_COEF_WIDTH)) - 1;
  localparam int RANDOM_ITEMS = 1827;
  localparam int HOLD_AT = 700;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 20;

  localparam field_t FMAX = 32'sh7FFF_FFFF;
  localparam field_t FMIN = 32'sh8000_0000;
  localparam coef_t CMAX = 16'sh7FFF;
  localparam coef_t CMIN = 16'sh8000;

  typedef struct {
    in_t  beat;
    bit   known;
    out_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  trcs_in_if  in_bus ();
  trcs_out_if out_bus ();

  tensor_rotation_cyl_sph #(
    .DATA_WIDTH(DUT_DATA_WIDTH),
    .COEF_WIDTH(DUT_COEF_WIDTH)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  always #1 clk = ~clk;

  out_t rotated_due[$];
  int   mismatches = 0;
  int   results_seen = 0;
  int   idle_cycles = 0;

  function automatic longint round_shift(input longint x, input int k);
    return (x + (longint'(1) << (k - 1))) >>> k;
  endfunction

  function automatic longint clamp(input longint x, input longint lo, input longint hi,
                                   inout bit hit);
    if (x > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (x < lo) begin
      hit = 1'b1;
      return lo;
    end
    return x;
  endfunction

  function automatic field_t saturate(input longint x, inout bit ov);
    longint hi;
    hi = (longint'(1) << (DW - 1)) - 1;
    return field_t'(clamp(x, -hi - 1, hi, ov));
  endfunction

  function automatic out_t rotate_tensor(input in_t b);
    longint s, c, a0, al, cu, cl, p3, p5, b1, b7;
    longint one, s2, c2, sg, sum08, dif08, sum26, dif26;
    longint r[8];
    bit inv, nine, ov, spare;
    out_t o;
    inv   = b.mode[MODE_INV_BIT];
    nine  = b.mode[MODE_NINE_BIT];
    s     = signed'(b.sine_theta);
    c     = signed'(b.cosine_theta);
    a0    = signed'(b.axial_first);
    al    = signed'(b.axial_last);
    cu    = signed'(b.cross_upper);
    cl    = signed'(b.cross_lower);
    p3    = signed'(b.pair_a_first);
    p5    = signed'(b.pair_a_second);
    b1    = signed'(b.pair_b_first);
    b7    = signed'(b.pair_b_second);
    one   = longint'(1) << FRAC;
    ov    = 1'b0;
    spare = 1'b0;
    s2    = clamp(round_shift(2 * s * c, FRAC), -one, one - 1, spare);
    c2    = clamp(round_shift(c * c - s * s, FRAC), -one, one - 1, spare);
    sg    = inv ? -1 : 1;
    sum08 = a0 + al;
    dif08 = a0 - al;
    sum26 = cu + cl;
    dif26 = cu - cl;
    foreach (r[k]) r[k] = 0;
    if (!nine) begin
      if (!inv) begin
        r[0] = round_shift(sum08 * one + c2 * dif08 - s2 * cu, FRAC + 1);
        r[2] = round_shift(c2 * cu + s2 * dif08, FRAC);
        r[4] = round_shift(c * p3 + s * p5, FRAC);
        r[5] = round_shift(c * p5 - s * p3, FRAC);
      end else begin
        r[0] = round_shift(sum08 * one + c2 * dif08 + 2 * s2 * cu, FRAC + 1);
        r[2] = round_shift(2 * c2 * cu - s2 * dif08, FRAC + 1);
        r[4] = round_shift(c * p3 - s * p5, FRAC);
        r[5] = round_shift(c * p5 + s * p3, FRAC);
      end
      r[1] = sum08 - r[0];
    end else begin
      r[0] = round_shift(sum08 * one + c2 * dif08 - sg * s2 * sum26, FRAC + 1);
      r[2] = round_shift(dif26 * one + c2 * sum26 + sg * s2 * dif08, FRAC + 1);
      r[3] = r[2] - dif26;
      r[1] = sum08 - r[0];
      r[6] = round_shift(c * b1 - sg * s * b7, FRAC);
      r[7] = round_shift(c * b7 + sg * s * b1, FRAC);
      r[4] = round_shift(c * p3 - sg * s * p5, FRAC);
      r[5] = round_shift(c * p5 + sg * s * p3, FRAC);
    end
    o.out_axial_first   = saturate(r[0], ov);
    o.out_axial_last    = saturate(r[1], ov);
    o.out_cross_upper   = saturate(r[2], ov);
    o.out_cross_lower   = saturate(r[3], ov);
    o.out_pair_a_first  = saturate(r[4], ov);
    o.out_pair_a_second = saturate(r[5], ov);
    o.out_pair_b_first  = saturate(r[6], ov);
    o.out_pair_b_second = saturate(r[7], ov);
    o.overflow          = ov;
    o.last_out          = b.last_item;
    return o;
  endfunction

  function automatic in_t mk(input logic [MODE_W-1:0] mode, input coef_t s, input coef_t c,
                             input field_t a0, input field_t al, input field_t cu,
                             input field_t cl, input field_t p3, input field_t p5,
                             input field_t b1, input field_t b7, input logic last);
    in_t b;
    b.mode          = mode;
    b.sine_theta    = s;
    b.cosine_theta  = c;
    b.axial_first   = a0;
    b.axial_last    = al;
    b.cross_upper   = cu;
    b.cross_lower   = cl;
    b.pair_a_first  = p3;
    b.pair_a_second = p5;
    b.pair_b_first  = b1;
    b.pair_b_second = b7;
    b.last_item     = last;
    return b;
  endfunction

  function automatic field_t rand_field();
    field_t v;
    case ($urandom_range(0, 3))
      0: v = $urandom;
      1: v = field_t'($urandom_range(0, 2000)) - 1000;
      2: v = $urandom_range(0, 1) ? FMAX - field_t'($urandom_range(0, 3))
                                  : FMIN + field_t'($urandom_range(0, 3));
      default: v = $signed($urandom) >>> $urandom_range(0, 31);
    endcase
    return v;
  endfunction

  function automatic in_t random_tensor();
    in_t b;
    real th;
    int pick;
    pick = $urandom_range(0, 9);
    b.mode = MODE_W'($urandom_range(0, 3));
    if (pick < 6) begin
      th = $urandom_range(0, 62831) / 10000.0;
      b.sine_theta   = coef_t'(int'(32767.0 * $sin(th)));
      b.cosine_theta = coef_t'(int'(32767.0 * $cos(th)));
    end else if (pick < 9) begin
      b.sine_theta   = coef_t'($urandom);
      b.cosine_theta = coef_t'($urandom);
    end else begin
      b.sine_theta   = $urandom_range(0, 1) ? CMIN : CMAX;
      b.cosine_theta = $urandom_range(0, 1) ? CMIN : -CMAX;
    end
    b.axial_first   = rand_field();
    b.axial_last    = rand_field();
    b.cross_upper   = rand_field();
    b.cross_lower   = rand_field();
    b.pair_a_first  = rand_field();
    b.pair_a_second = rand_field();
    b.pair_b_first  = rand_field();
    b.pair_b_second = rand_field();
    b.last_item     = ($urandom_range(0, 7) == 0);
    return b;
  endfunction

  task automatic put_beat(input in_t b);
    in_bus.mode          <= b.mode;
    in_bus.sine_theta    <= b.sine_theta;
    in_bus.cosine_theta  <= b.cosine_theta;
    in_bus.axial_first   <= b.axial_first;
    in_bus.axial_last    <= b.axial_last;
    in_bus.cross_upper   <= b.cross_upper;
    in_bus.cross_lower   <= b.cross_lower;
    in_bus.pair_a_first  <= b.pair_a_first;
    in_bus.pair_a_second <= b.pair_a_second;
    in_bus.pair_b_first  <= b.pair_b_first;
    in_bus.pair_b_second <= b.pair_b_second;
    in_bus.last_item     <= b.last_item;
  endtask

  task automatic send_beat(input in_t b, input bit known, input out_t want, input int idx);
    int gap;
    gap = (((idx / 150) % 4) == 3) ? 0 : $urandom_range(0, 3);
    @(negedge clk);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    put_beat(b);
    in_bus.valid <= 1'b1;
    do @(posedge clk); while (!in_bus.ready);
    rotated_due.push_back(known ? want : rotate_tensor(b));
  endtask

  task automatic compare_field(input string name, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch in %s of result %0d: expected %h, got %h",
                 name, results_seen, want, got);
    end
  endtask

  task automatic check_rotated(input out_t got);
    out_t want;
    if (rotated_due.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result beat %0d", results_seen);
    end else begin
      want = rotated_due.pop_front();
      compare_field("out_axial_first", want.out_axial_first, got.out_axial_first);
      compare_field("out_axial_last", want.out_axial_last, got.out_axial_last);
      compare_field("out_cross_upper", want.out_cross_upper, got.out_cross_upper);
      compare_field("out_cross_lower", want.out_cross_lower, got.out_cross_lower);
      compare_field("out_pair_a_first", want.out_pair_a_first, got.out_pair_a_first);
      compare_field("out_pair_a_second", want.out_pair_a_second, got.out_pair_a_second);
      compare_field("out_pair_b_first", want.out_pair_b_first, got.out_pair_b_first);
      compare_field("out_pair_b_second", want.out_pair_b_second, got.out_pair_b_second);
      compare_field("overflow", want.overflow, got.overflow);
      compare_field("last_out", want.last_out, got.last_out);
    end
    results_seen++;
  endtask

  always @(posedge clk) begin
    out_t got;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.out_axial_first   = out_bus.out_axial_first;
      got.out_axial_last    = out_bus.out_axial_last;
      got.out_cross_upper   = out_bus.out_cross_upper;
      got.out_cross_lower   = out_bus.out_cross_lower;
      got.out_pair_a_first  = out_bus.out_pair_a_first;
      got.out_pair_a_second = out_bus.out_pair_a_second;
      got.out_pair_b_first  = out_bus.out_pair_b_first;
      got.out_pair_b_second = out_bus.out_pair_b_second;
      got.overflow          = out_bus.overflow;
      got.last_out          = out_bus.last_out;
      check_rotated(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // The receiver holds off once for a long stretch so that the pipeline fills and stalls in_i.
  initial begin
    int stall;
    int taken;
    bit held;
    taken = 0;
    held = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      stall = (((taken / 160) % 4) == 3) ? 0 : $urandom_range(0, 3);
      @(negedge clk);
      if (!held && taken == HOLD_AT) begin
        held = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (stall > 0) begin
        out_bus.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      do @(posedge clk); while (!out_bus.valid);
      taken++;
    end
  end

  initial begin
    stim_row_t rows[$];
    out_t want;
    int idx;
    in_bus.valid = 1'b0;
    put_beat('0);
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    want = '0;
    rows.push_back('{mk(MODE_SIX_FWD, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, want});
    rows.push_back('{mk(MODE_SIX_FWD, 0, 0, 0, 0, 0, -1, 0, 0, FMAX, FMIN, 1'b0), 1'b1, want});
    want.last_out = 1'b1;
    rows.push_back('{mk(MODE_NINE_INV, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1), 1'b1, want});
    want = '0;
    want.out_axial_first = 100;
    want.out_axial_last  = 100;
    rows.push_back('{mk(MODE_SIX_FWD, 0, 0, 100, 100, 0, 0, 0, 0, 0, 0, 1'b0), 1'b1, want});
    want = '0;
    want.out_pair_a_first = FMAX;
    want.overflow = 1'b1;
    want.last_out = 1'b1;
    rows.push_back('{mk(MODE_SIX_FWD, 0, CMIN, 0, 0, 0, 0, FMIN, 0, 0, 0, 1'b1), 1'b1, want});
    want = '0;
    for (int m = 0; m < 4; m++) begin
      rows.push_back('{mk(MODE_W'(m), 12540, 30274, 1000000, -2500000, 333333, -77777,
                          123456789, -987654, 55555, -4444444, 1'b0), 1'b0, want});
      rows.push_back('{mk(MODE_W'(m), CMAX, CMAX, FMAX, FMAX, FMAX, FMAX, FMAX, FMAX,
                          FMAX, FMAX, 1'b0), 1'b0, want});
      rows.push_back('{mk(MODE_W'(m), CMIN, CMIN, FMIN, FMIN, FMIN, FMIN, FMIN, FMIN,
                          FMIN, FMIN, 1'b1), 1'b0, want});
    end
    rows.push_back('{mk(MODE_SIX_INV, CMIN, CMAX, FMAX, FMIN, FMAX, 0, FMIN, FMAX, 0, 0,
                        1'b0), 1'b0, want});
    rows.push_back('{mk(MODE_NINE_FWD, CMAX, CMIN, FMIN, FMAX, FMIN, FMAX, FMAX, FMIN,
                        FMIN, FMAX, 1'b0), 1'b0, want});
    rows.push_back('{mk(MODE_NINE_INV, 0, CMAX, 7, -9, 11, -13, 15, -17, 19, -21, 1'b1),
                     1'b0, want});
    rows.push_back('{mk(MODE_SIX_FWD, CMAX, 0, 5000, -6000, 7000, 0, -8000, 9000, 0, 0,
                        1'b0), 1'b0, want});
    rows.push_back('{mk(MODE_NINE_FWD, -23170, 23170, 1, 0, -1, 0, 1, -1, 1, 1, 1'b0),
                     1'b0, want});
    rows.push_back('{mk(MODE_NINE_INV, CMIN, CMIN, 3, -3, 5, -5, 1000, -1000, 77, -77,
                        1'b1), 1'b0, want});

    idx = 0;
    foreach (rows[i]) begin
      send_beat(rows[i].beat, rows[i].known, rows[i].want, idx);
      idx++;
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send_beat(random_tensor(), 1'b0, want, idx);
      idx++;
    end
    @(negedge clk);
    in_bus.valid <= 1'b0;

    while (rotated_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
